@@ rtl/htae_pkg.sv @@
package htae_pkg;

    // Fixed geometry of the tile grid and of the curve.
    localparam int GRID_ROWS    = 16;
    localparam int CURVE_SIDE   = 128;
    localparam int CURVE_BITS   = 7;
    localparam int FIELD_W      = 4;
    localparam int SPAN_W       = 4;
    localparam int NUM_W        = FIELD_W + CURVE_BITS;
    localparam int INDEX_W      = 14;
    localparam int ADDR_W       = 32;
    localparam int REGION_LIMIT = 12;
    localparam int INDEX_SHIFT  = 14;
    localparam int REGION_SHIFT = 28;

    // Quotient bits at and above this position are resolved in the first divide stage.
    localparam int DIV_SPLIT = 4;

    // One classified tile as it waits between the front and the back.
    typedef struct packed {
        logic [FIELD_W-1:0] region;
        logic               ridge;
        logic               pole;
        logic [NUM_W-1:0]   num_x;
        logic [SPAN_W-1:0]  span_x;
        logic [NUM_W-1:0]   num_y;
        logic [SPAN_W-1:0]  span_y;
    } t_work;

    // Result of one restoring division step.
    typedef struct packed {
        logic             q;
        logic [NUM_W-1:0] rem;
    } t_div;

    // One restoring division step for quotient bit k.
    function automatic t_div div_step(input logic [NUM_W-1:0] rem,
                                      input logic [SPAN_W-1:0] span,
                                      input int k);
        t_div             res;
        logic [NUM_W-1:0] shifted;
        shifted = NUM_W'(span) << k;
        if (rem >= shifted) begin
            res.q   = 1'b1;
            res.rem = rem - shifted;
        end else begin
            res.q   = 1'b0;
            res.rem = rem;
        end
        return res;
    endfunction

    // Hilbert xy-to-index mapping, one level per bit from the top down.
    // Coordinates wrap within their own width; only bits below the level are tested later.
    function automatic logic [INDEX_W-1:0] curve_order_index(input logic [CURVE_BITS-1:0] x_in,
                                                             input logic [CURVE_BITS-1:0] y_in);
        logic [CURVE_BITS-1:0] x;
        logic [CURVE_BITS-1:0] y;
        logic [CURVE_BITS-1:0] t;
        logic [CURVE_BITS-1:0] smask;
        logic                  bx;
        logic                  by;
        logic [INDEX_W-1:0]    d;
        x = x_in;
        y = y_in;
        d = '0;
        for (int k = CURVE_BITS - 1; k >= 0; k--) begin
            bx    = x[k];
            by    = y[k];
            d     = d | (INDEX_W'({bx, bx ^ by}) << (2 * k));
            smask = CURVE_BITS'((1 << k) - 1);
            if (!by) begin
                if (bx) begin
                    x = smask - x;
                    y = smask - y;
                end
                t = x;
                x = y;
                y = t;
            end
        end
        return d;
    endfunction

endpackage

@@ rtl/htae_front.sv @@
module htae_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [htae_pkg::FIELD_W-1:0]        i_tile_col,
    input  logic [htae_pkg::FIELD_W-1:0]        i_tile_row,
    input  logic [htae_pkg::FIELD_W-1:0]        i_region_id,
    input  logic [htae_pkg::FIELD_W-1:0]        i_box_col_min,
    input  logic [htae_pkg::FIELD_W-1:0]        i_box_row_min,
    input  logic [htae_pkg::FIELD_W-1:0]        i_box_col_max,
    input  logic [htae_pkg::FIELD_W-1:0]        i_box_row_max,
    input  logic                                i_ridge_in,
    output logic                                o_push,
    input  logic                                i_push_ready,
    output htae_pkg::t_work                     o_item
);

    typedef struct packed {
        logic [htae_pkg::NUM_W-1:0]  num;
        logic [htae_pkg::SPAN_W-1:0] span;
    } t_axis;

    // Clamp the tile offset into the box and scale it up by the curve side minus one.
    // A degenerate or inverted box gives a zero numerator over a span of one.
    function automatic t_axis prep_axis(input logic [htae_pkg::FIELD_W-1:0] pos,
                                        input logic [htae_pkg::FIELD_W-1:0] lo,
                                        input logic [htae_pkg::FIELD_W-1:0] hi);
        t_axis                         res;
        logic [htae_pkg::FIELD_W-1:0]  off;
        if (hi <= lo) begin
            res.num  = '0;
            res.span = htae_pkg::SPAN_W'(1);
        end else begin
            res.span = hi - lo;
            if (pos < lo) begin
                off = '0;
            end else if (pos > hi) begin
                off = hi - lo;
            end else begin
                off = pos - lo;
            end
            res.num = htae_pkg::NUM_W'(off) * htae_pkg::NUM_W'(htae_pkg::CURVE_SIDE - 1);
        end
        return res;
    endfunction

    logic            r_valid;
    htae_pkg::t_work r_item;
    htae_pkg::t_work n_item;
    t_axis           ax;
    t_axis           ay;
    logic            accept;

    assign o_stall = r_valid && !i_push_ready;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    // Classify the beat: unassigned regions collapse to a zero item.
    // Their spans are one, so the divider returns zero coordinates and index.
    always_comb begin
        ax            = prep_axis(i_tile_col, i_box_col_min, i_box_col_max);
        ay            = prep_axis(i_tile_row, i_box_row_min, i_box_row_max);
        n_item        = '0;
        n_item.span_x = htae_pkg::SPAN_W'(1);
        n_item.span_y = htae_pkg::SPAN_W'(1);
        if (i_region_id < htae_pkg::FIELD_W'(htae_pkg::REGION_LIMIT)) begin
            n_item.region = i_region_id;
            n_item.ridge  = i_ridge_in;
            n_item.pole   = (i_tile_row <= htae_pkg::FIELD_W'(1)) ||
                            ((int'(i_tile_row) + 2) >= htae_pkg::GRID_ROWS);
            n_item.num_x  = ax.num;
            n_item.span_x = ax.span;
            n_item.num_y  = ay.num;
            n_item.span_y = ay.span;
        end
    end

    // Front register holds one classified beat until the queue takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

@@ rtl/htae_queue.sv @@
module htae_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  htae_pkg::t_work i_item,
    output logic            o_valid,
    input  logic            i_pop,
    output htae_pkg::t_work o_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    htae_pkg::t_work    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_item  = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue fill count above depth");

    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not grow on push");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue count did not shrink on pop");
`endif

endmodule

@@ rtl/htae_back.sv @@
module htae_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_pop,
    input  htae_pkg::t_work                   i_item,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [htae_pkg::FIELD_W-1:0]      o_region_out,
    output logic [htae_pkg::INDEX_W-1:0]      o_curve_index,
    output logic                              o_ridge_flag,
    output logic                              o_pole_flag,
    output logic [htae_pkg::ADDR_W-1:0]       o_packed_address
);

    // Partial division state after the upper quotient bits.
    typedef struct packed {
        logic [htae_pkg::FIELD_W-1:0]    region;
        logic                            ridge;
        logic                            pole;
        logic [htae_pkg::NUM_W-1:0]      rem_x;
        logic [htae_pkg::SPAN_W-1:0]     span_x;
        logic [htae_pkg::CURVE_BITS-1:0] q_x;
        logic [htae_pkg::NUM_W-1:0]      rem_y;
        logic [htae_pkg::SPAN_W-1:0]     span_y;
        logic [htae_pkg::CURVE_BITS-1:0] q_y;
    } t_div_st;

    // Scaled point on the curve grid.
    typedef struct packed {
        logic [htae_pkg::FIELD_W-1:0]    region;
        logic                            ridge;
        logic                            pole;
        logic [htae_pkg::CURVE_BITS-1:0] x;
        logic [htae_pkg::CURVE_BITS-1:0] y;
    } t_point;

    // Finished result.
    typedef struct packed {
        logic [htae_pkg::FIELD_W-1:0] region;
        logic                         ridge;
        logic                         pole;
        logic [htae_pkg::INDEX_W-1:0] index;
    } t_result;

    logic          r_v1;
    logic          r_v2;
    logic          r_vo;
    t_div_st       r_s1;
    t_div_st       n_s1;
    t_point        r_s2;
    t_point        n_s2;
    t_result       r_out;
    t_result       n_out;
    htae_pkg::t_div dx;
    htae_pkg::t_div dy;
    logic          rdy_o;
    logic          rdy_2;
    logic          rdy_1;

    // Each stage advances when it is empty or the stage after it moves.
    assign rdy_o = !r_vo || !i_stall;
    assign rdy_2 = !r_v2 || rdy_o;
    assign rdy_1 = !r_v1 || rdy_2;
    assign o_pop = i_valid && rdy_1;

    // Stage one: upper quotient bits of both axes.
    always_comb begin
        n_s1        = '0;
        n_s1.region = i_item.region;
        n_s1.ridge  = i_item.ridge;
        n_s1.pole   = i_item.pole;
        n_s1.span_x = i_item.span_x;
        n_s1.span_y = i_item.span_y;
        n_s1.rem_x  = i_item.num_x;
        n_s1.rem_y  = i_item.num_y;
        for (int k = htae_pkg::CURVE_BITS - 1; k >= htae_pkg::DIV_SPLIT; k--) begin
            dx         = htae_pkg::div_step(n_s1.rem_x, n_s1.span_x, k);
            dy         = htae_pkg::div_step(n_s1.rem_y, n_s1.span_y, k);
            n_s1.q_x[k] = dx.q;
            n_s1.rem_x  = dx.rem;
            n_s1.q_y[k] = dy.q;
            n_s1.rem_y  = dy.rem;
        end
    end

    // Stage two: lower quotient bits, giving the scaled coordinates.
    always_comb begin
        t_div_st        w;
        htae_pkg::t_div sx;
        htae_pkg::t_div sy;
        w = r_s1;
        for (int k = htae_pkg::DIV_SPLIT - 1; k >= 0; k--) begin
            sx       = htae_pkg::div_step(w.rem_x, w.span_x, k);
            sy       = htae_pkg::div_step(w.rem_y, w.span_y, k);
            w.q_x[k] = sx.q;
            w.rem_x  = sx.rem;
            w.q_y[k] = sy.q;
            w.rem_y  = sy.rem;
        end
        n_s2.region = w.region;
        n_s2.ridge  = w.ridge;
        n_s2.pole   = w.pole;
        n_s2.x      = w.q_x;
        n_s2.y      = w.q_y;
    end

    // Stage three: walk the curve levels to get the index.
    always_comb begin
        n_out.region = r_s2.region;
        n_out.ridge  = r_s2.ridge;
        n_out.pole   = r_s2.pole;
        n_out.index  = htae_pkg::curve_order_index(r_s2.x, r_s2.y);
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy_1) begin
                r_v1 <= i_valid;
            end
            if (rdy_2) begin
                r_v2 <= r_v1;
            end
            if (rdy_o) begin
                r_vo <= r_v2;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= n_s1;
        end
        if (rdy_2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (rdy_o && r_v2) begin
            r_out <= n_out;
        end
    end

    assign o_valid          = r_vo;
    assign o_region_out     = r_out.region;
    assign o_curve_index    = r_out.index;
    assign o_ridge_flag     = r_out.ridge;
    assign o_pole_flag      = r_out.pole;
    assign o_packed_address = {r_out.region, r_out.index, {htae_pkg::INDEX_SHIFT{1'b0}}};

endmodule

@@ rtl/hilbert_tile_address_encoder_top.sv @@
// Hilbert tile address encoder.
// Input channel: i_valid / o_stall with one tile per beat (column, row, region,
// bounding box and ridge bit). Output channel: o_valid / i_stall with one result
// per beat (region, 14-bit curve index, ridge flag, pole flag, packed address).
// A beat moves at a rising edge where valid is high and stall is low.
// Throughput is one tile per cycle while neither side stalls; the path is
// set by the front register, the queue, two divide stages that scale each
// axis onto the 128x128 grid and one stage that walks the seven curve levels
// into the output register.
// The queue holds QUEUE_DEPTH classified tiles, so the front keeps taking beats
// while the back is stalled; o_stall rises only once the front register and
// the queue are both full.
// Unassigned regions produce an all-zero result beat.
// Reset is synchronous and active low: it empties the front register, the
// queue and the back stages; no result is shown until new beats arrive.
// While i_stall is high the result on the output ports holds steady.
module hilbert_tile_address_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [htae_pkg::FIELD_W-1:0]      i_tile_col,
    input  logic [htae_pkg::FIELD_W-1:0]      i_tile_row,
    input  logic [htae_pkg::FIELD_W-1:0]      i_region_id,
    input  logic [htae_pkg::FIELD_W-1:0]      i_box_col_min,
    input  logic [htae_pkg::FIELD_W-1:0]      i_box_row_min,
    input  logic [htae_pkg::FIELD_W-1:0]      i_box_col_max,
    input  logic [htae_pkg::FIELD_W-1:0]      i_box_row_max,
    input  logic                              i_ridge_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [htae_pkg::FIELD_W-1:0]      o_region_out,
    output logic [htae_pkg::INDEX_W-1:0]      o_curve_index,
    output logic                              o_ridge_flag,
    output logic                              o_pole_flag,
    output logic [htae_pkg::ADDR_W-1:0]       o_packed_address
);

    logic            push;
    logic            push_ready;
    logic            q_valid;
    logic            pop;
    htae_pkg::t_work front_item;
    htae_pkg::t_work q_item;

    // Front: takes beats and classifies them.
    htae_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_tile_col   (i_tile_col),
        .i_tile_row   (i_tile_row),
        .i_region_id  (i_region_id),
        .i_box_col_min(i_box_col_min),
        .i_box_row_min(i_box_row_min),
        .i_box_col_max(i_box_col_max),
        .i_box_row_max(i_box_row_max),
        .i_ridge_in   (i_ridge_in),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_item       (front_item)
    );

    // Queue between front and back.
    htae_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_ready(push_ready),
        .i_item (front_item),
        .o_valid(q_valid),
        .i_pop  (pop),
        .o_item (q_item)
    );

    // Back: scaling, curve index and output register.
    htae_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_pop           (pop),
        .i_item          (q_item),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_region_out    (o_region_out),
        .o_curve_index   (o_curve_index),
        .o_ridge_flag    (o_ridge_flag),
        .o_pole_flag     (o_pole_flag),
        .o_packed_address(o_packed_address)
    );

endmodule

@@ test/tb.sv @@
module tb;

    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_TILES   = 700;
    localparam int HOLDOFF_CYCLES = 60;
    localparam int HOLDOFF_AFTER  = 100;
    localparam int IDLE_LIMIT     = 1000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int REPORT_LIMIT   = 10;
    localparam int DIRECTED_N     = 19;

    // One tile as it enters the encoder.
    typedef struct packed {
        logic [htae_pkg::FIELD_W-1:0] col;
        logic [htae_pkg::FIELD_W-1:0] row;
        logic [htae_pkg::FIELD_W-1:0] region;
        logic [htae_pkg::FIELD_W-1:0] cmin;
        logic [htae_pkg::FIELD_W-1:0] rmin;
        logic [htae_pkg::FIELD_W-1:0] cmax;
        logic [htae_pkg::FIELD_W-1:0] rmax;
        logic                         ridge;
    } t_tile;

    // One encoded tile address as it leaves the encoder.
    typedef struct packed {
        logic [htae_pkg::FIELD_W-1:0] region;
        logic [htae_pkg::INDEX_W-1:0] index;
        logic                         ridge;
        logic                         pole;
        logic [htae_pkg::ADDR_W-1:0]  address;
    } t_tile_addr;

    // A directed tile, with its address typed in where it is obvious.
    typedef struct packed {
        t_tile      tile;
        logic       typed;
        t_tile_addr addr;
    } t_directed;

    localparam t_tile_addr NO_ADDR = '0;

    localparam t_directed DIRECTED_TILES [DIRECTED_N] = '{
        // Box corners at full extent.
        '{'{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd15, 4'd15, 1'b0}, 1'b1,
          '{4'd0, 14'd0, 1'b0, 1'b1, 32'h0000_0000}},
        '{'{4'd15, 4'd0, 4'd11, 4'd0, 4'd0, 4'd15, 4'd15, 1'b1}, 1'b1,
          '{4'd11, 14'd16383, 1'b1, 1'b1, 32'hBFFF_C000}},
        // Unassigned regions give an all-zero address.
        '{'{4'd15, 4'd15, 4'd12, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1}, 1'b1, NO_ADDR},
        '{'{4'd6, 4'd9, 4'd15, 4'd1, 4'd2, 4'd12, 4'd13, 1'b1}, 1'b1, NO_ADDR},
        // Inverted column box scales that axis to zero.
        '{'{4'd7, 4'd0, 4'd5, 4'd9, 4'd0, 4'd3, 4'd15, 1'b0}, 1'b1,
          '{4'd5, 14'd0, 1'b0, 1'b1, 32'h5000_0000}},
        // Box of extent one on both axes.
        '{'{4'd4, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 1'b1}, 1'b1,
          '{4'd3, 14'd0, 1'b1, 1'b0, 32'h3000_0000}},
        // Both axes inverted, tile in the bottom pole rows.
        '{'{4'd0, 4'd15, 4'd11, 4'd15, 4'd15, 4'd0, 4'd0, 1'b0}, 1'b1,
          '{4'd11, 14'd0, 1'b0, 1'b1, 32'hB000_0000}},
        // Remaining corners, outside-of-box saturation and pole boundaries.
        '{'{4'd0, 4'd15, 4'd1, 4'd0, 4'd0, 4'd15, 4'd15, 1'b0}, 1'b0, NO_ADDR},
        '{'{4'd15, 4'd15, 4'd2, 4'd0, 4'd0, 4'd15, 4'd15, 1'b1}, 1'b0, NO_ADDR},
        '{'{4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd10, 4'd12, 1'b0}, 1'b0, NO_ADDR},
        '{'{4'd14, 4'd13, 4'd6, 4'd1, 4'd2, 4'd8, 4'd9, 1'b1}, 1'b0, NO_ADDR},
        '{'{4'd3, 4'd1, 4'd7, 4'd0, 4'd0, 4'd15, 4'd15, 1'b0}, 1'b0, NO_ADDR},
        '{'{4'd9, 4'd2, 4'd8, 4'd0, 4'd0, 4'd15, 4'd15, 1'b1}, 1'b0, NO_ADDR},
        '{'{4'd11, 4'd13, 4'd9, 4'd0, 4'd0, 4'd15, 4'd15, 1'b0}, 1'b0, NO_ADDR},
        '{'{4'd12, 4'd14, 4'd10, 4'd0, 4'd0, 4'd15, 4'd15, 1'b1}, 1'b0, NO_ADDR},
        // Spans that are not powers of two, and the shortest spans.
        '{'{4'd5, 4'd9, 4'd0, 4'd2, 4'd3, 4'd12, 4'd14, 1'b1}, 1'b0, NO_ADDR},
        '{'{4'd7, 4'd8, 4'd1, 4'd6, 4'd8, 4'd7, 4'd9, 1'b0}, 1'b0, NO_ADDR},
        '{'{4'd9, 4'd10, 4'd2, 4'd8, 4'd9, 4'd10, 4'd11, 1'b1}, 1'b0, NO_ADDR},
        '{'{4'd15, 4'd7, 4'd3, 4'd12, 4'd0, 4'd15, 4'd15, 1'b0}, 1'b0, NO_ADDR}
    };

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [htae_pkg::FIELD_W-1:0] i_tile_col;
    logic [htae_pkg::FIELD_W-1:0] i_tile_row;
    logic [htae_pkg::FIELD_W-1:0] i_region_id;
    logic [htae_pkg::FIELD_W-1:0] i_box_col_min;
    logic [htae_pkg::FIELD_W-1:0] i_box_row_min;
    logic [htae_pkg::FIELD_W-1:0] i_box_col_max;
    logic [htae_pkg::FIELD_W-1:0] i_box_row_max;
    logic                         i_ridge_in;
    logic                         o_valid;
    logic                         i_stall;
    logic [htae_pkg::FIELD_W-1:0] o_region_out;
    logic [htae_pkg::INDEX_W-1:0] o_curve_index;
    logic                         o_ridge_flag;
    logic                         o_pole_flag;
    logic [htae_pkg::ADDR_W-1:0]  o_packed_address;

    t_tile_addr pending_addrs[$];
    t_tile_addr want;
    int         mismatches     = 0;
    int         addrs_seen     = 0;
    int         idle_cycles    = 0;
    bit         holdoff_active = 1'b0;
    bit         holdoff_done   = 1'b0;
    bit         sender_quiet   = 1'b0;

    hilbert_tile_address_encoder_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_tile_col       (i_tile_col),
        .i_tile_row       (i_tile_row),
        .i_region_id      (i_region_id),
        .i_box_col_min    (i_box_col_min),
        .i_box_row_min    (i_box_row_min),
        .i_box_col_max    (i_box_col_max),
        .i_box_row_max    (i_box_row_max),
        .i_ridge_in       (i_ridge_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_region_out     (o_region_out),
        .o_curve_index    (o_curve_index),
        .o_ridge_flag     (o_ridge_flag),
        .o_pole_flag      (o_pole_flag),
        .o_packed_address (o_packed_address)
    );

    // Free-running clock with a period of 8.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Maps one position inside a box onto the curve grid, saturating outside the box.
    function automatic int unsigned grid_coord(input int unsigned pos, input int unsigned lo,
                                               input int unsigned hi);
        int unsigned span;
        int unsigned offset;
        if (hi <= lo) begin
            return 0;
        end
        span = hi - lo;
        if (pos < lo) begin
            offset = 0;
        end else if (pos > hi) begin
            offset = span;
        end else begin
            offset = pos - lo;
        end
        return offset * (htae_pkg::CURVE_SIDE - 1) / span;
    endfunction

    // Index along the Hilbert curve, walked from the largest quadrant down.
    function automatic logic [htae_pkg::INDEX_W-1:0] curve_position(input int unsigned px,
                                                                    input int unsigned py);
        int unsigned quad;
        int unsigned bx;
        int unsigned by;
        int unsigned swap;
        int unsigned walk_d;
        walk_d = 0;
        for (quad = htae_pkg::CURVE_SIDE / 2; quad > 0; quad = quad / 2) begin
            bx = ((px & quad) != 0) ? 1 : 0;
            by = ((py & quad) != 0) ? 1 : 0;
            walk_d = walk_d + quad * quad * ((3 * bx) ^ by);
            if (by == 0) begin
                if (bx == 1) begin
                    px = quad - 1 - px;
                    py = quad - 1 - py;
                end
                swap = px;
                px   = py;
                py   = swap;
            end
        end
        return walk_d[htae_pkg::INDEX_W-1:0];
    endfunction

    // Full address of one tile.
    function automatic t_tile_addr encode_tile(input t_tile t);
        t_tile_addr a;
        a = '0;
        if (t.region >= htae_pkg::REGION_LIMIT) begin
            return a;
        end
        a.region  = t.region;
        a.index   = curve_position(grid_coord(t.col, t.cmin, t.cmax),
                                   grid_coord(t.row, t.rmin, t.rmax));
        a.ridge   = t.ridge;
        a.pole    = (int'(t.row) <= 1 || int'(t.row) + 2 >= htae_pkg::GRID_ROWS);
        a.address = (htae_pkg::ADDR_W'(a.region) << htae_pkg::REGION_SHIFT) |
                    (htae_pkg::ADDR_W'(a.index) << htae_pkg::INDEX_SHIFT);
        return a;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap(input bit quiet);
        int roll;
        if (quiet) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    // Random tile: mostly well-formed boxes with the tile inside, some outside or inverted.
    function automatic t_tile random_tile();
        t_tile t;
        int    shape;
        int    lo;
        int    hi;
        shape    = $urandom_range(0, 99);
        t        = t_tile'(($bits(t_tile))'({$urandom, $urandom}));
        t.region = ($urandom_range(0, 7) == 0) ? htae_pkg::FIELD_W'($urandom_range(12, 15))
                                                : htae_pkg::FIELD_W'($urandom_range(0, 11));
        if (shape < 85) begin
            lo     = $urandom_range(0, 15);
            hi     = $urandom_range(15, lo);
            t.cmin = htae_pkg::FIELD_W'(lo);
            t.cmax = htae_pkg::FIELD_W'(hi);
            if (shape < 70) begin
                t.col = htae_pkg::FIELD_W'($urandom_range(hi, lo));
            end
            lo     = $urandom_range(0, 15);
            hi     = $urandom_range(15, lo);
            t.rmin = htae_pkg::FIELD_W'(lo);
            t.rmax = htae_pkg::FIELD_W'(hi);
            if (shape < 70) begin
                t.row = htae_pkg::FIELD_W'($urandom_range(hi, lo));
            end
        end
        return t;
    endfunction

    // Offers one tile, holds it until it is taken, then idles for a random gap.
    task automatic send_tile(input t_tile t, input logic typed, input t_tile_addr typed_addr);
        int gap;
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_tile_col    <= t.col;
        i_tile_row    <= t.row;
        i_region_id   <= t.region;
        i_box_col_min <= t.cmin;
        i_box_row_min <= t.rmin;
        i_box_col_max <= t.cmax;
        i_box_row_max <= t.rmax;
        i_ridge_in    <= t.ridge;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        pending_addrs.push_back(typed ? typed_addr : encode_tile(t));
        gap = holdoff_active ? 0 : pick_gap(sender_quiet);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] expd,
                               input logic [31:0] got);
        if (expd !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("Mismatch on %s at address beat %0d: expected %0h, got %0h",
                         what, addrs_seen, expd, got);
            end
        end
    endtask

    // Stimulus: reset, the directed table, then random tiles.
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_tile_col    = '0;
        i_tile_row    = '0;
        i_region_id   = '0;
        i_box_col_min = '0;
        i_box_row_min = '0;
        i_box_col_max = '0;
        i_box_row_max = '0;
        i_ridge_in    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_N; n++) begin
            send_tile(DIRECTED_TILES[n].tile, DIRECTED_TILES[n].typed, DIRECTED_TILES[n].addr);
        end
        for (int n = 0; n < RANDOM_TILES; n++) begin
            if (n % 50 == 0) begin
                sender_quiet = ($urandom_range(0, 3) == 0);
            end
            send_tile(random_tile(), 1'b0, NO_ADDR);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // Wait for every address, then a little longer for anything stray.
        while (pending_addrs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver stalls: random gaps, quiet stretches and one long hold-off.
    initial begin
        int gap;
        bit quiet;
        i_stall = 1'b0;
        quiet   = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!holdoff_done && addrs_seen >= HOLDOFF_AFTER) begin
                holdoff_active = 1'b1;
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(negedge i_clk);
                holdoff_active = 1'b0;
                holdoff_done   = 1'b1;
            end
            if ($urandom_range(0, 39) == 0) begin
                quiet = !quiet;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            gap = pick_gap(quiet);
            if (gap > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    // Compare each accepted address beat with the oldest pending address.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_addrs.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Unexpected address beat: region %0h index %0h address %0h",
                             o_region_out, o_curve_index, o_packed_address);
                end
            end else begin
                want = pending_addrs.pop_front();
                check_field("region_out", 32'(want.region), 32'(o_region_out));
                check_field("curve_index", 32'(want.index), 32'(o_curve_index));
                check_field("ridge_flag", 32'(want.ridge), 32'(o_ridge_flag));
                check_field("pole_flag", 32'(want.pole), 32'(o_pole_flag));
                check_field("packed_address", want.address, o_packed_address);
                addrs_seen++;
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
rtl/htae_pkg.sv
rtl/htae_front.sv
rtl/htae_queue.sv
rtl/htae_back.sv
rtl/hilbert_tile_address_encoder_top.sv
test/tb.sv
